// ===== rtl/ibd_pkg.sv =====
`default_nettype none

package ibd_pkg;

  localparam int PIX_W       = 8;
  localparam int SUM_W       = 16;
  localparam int FACTOR_W    = 5;
  localparam int DIM_W       = 13;
  localparam int ROW_W       = 12;
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 26;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic [DIM_W-1:0]    HEIGHT_LIMIT = 13'd4096;
  localparam logic [FACTOR_W-1:0] GAUSS_FACTOR = 5'd3;

  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_COLOR  = 2'd3;

  typedef struct packed {
    logic       in_block;
    logic       sc0;
    logic       first;
    logic [1:0] wshift;
    logic       blk_wr;
    logic       last;
    logic       row_end;
    logic       frame_end;
  } pix_ctl_t;

  typedef struct packed {
    logic       accept;
    logic       acc_en;
    logic       wr_en;
    logic       load2;
    logic       load3;
    logic       first;
    logic       sc0;
    logic [1:0] wshift;
  } lane_cmd_t;

  // Reciprocals rounded up, scaled by 2**RECIP_SHIFT, of the block divisor.
  // The Gaussian factor divides by 16.
  function automatic logic [RECIP_W-1:0] recip_of(input logic [FACTOR_W-1:0] f);
    logic [RECIP_W-1:0] r;
    case (f)
      5'd2:    r = 25'd16777216;
      5'd3:    r = 25'd4194304;
      5'd4:    r = 25'd4194304;
      5'd6:    r = 25'd1864136;
      5'd8:    r = 25'd1048576;
      5'd10:   r = 25'd671089;
      5'd12:   r = 25'd466034;
      5'd14:   r = 25'd342393;
      5'd16:   r = 25'd262144;
      5'd18:   r = 25'd207127;
      5'd20:   r = 25'd167773;
      5'd22:   r = 25'd138655;
      5'd24:   r = 25'd116509;
      5'd26:   r = 25'd99274;
      5'd28:   r = 25'd85599;
      5'd30:   r = 25'd74566;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ibd_ram.sv =====
`default_nettype none

module ibd_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 2048,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/ibd_ctrl.sv =====
`default_nettype none

module ibd_ctrl #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 16,
  localparam int DEPTH     = MAX_WIDTH / 2,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             accept,
  input  wire logic                             restart,
  input  wire logic [ibd_pkg::FACTOR_W-1:0]     scale,
  input  wire logic [ibd_pkg::DIM_W-1:0]        width,
  input  wire logic [ibd_pkg::DIM_W-1:0]        height,
  output ibd_pkg::pix_ctl_t                     ctl,
  output logic      [AW-1:0]                    addr
);

  localparam int ICW = $clog2(MAX_WIDTH);
  localparam int WEW = $clog2(MAX_WIDTH + 1);
  localparam int CW  = ((WEW > ibd_pkg::DIM_W) ? WEW : ibd_pkg::DIM_W) + 1;
  localparam int SW  = (MAX_FACTOR > 32) ? ibd_pkg::FACTOR_W : $clog2(MAX_FACTOR);
  localparam int EW  = ibd_pkg::FACTOR_W + 1;
  localparam int RW  = ibd_pkg::DIM_W + 1;

  localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);
  localparam logic [6:0]    MAXF = 7'(MAX_FACTOR);

  logic [ICW-1:0]             ic_r, ic_nxt;
  logic [ibd_pkg::ROW_W-1:0]  ir_r, ir_nxt;
  logic [SW-1:0]              sc_r, sc_nxt;
  logic [SW-1:0]              sr_r, sr_nxt;
  logic [AW-1:0]              oc_r, oc_nxt;
  logic                       row_ok_r, row_ok_nxt;

  logic                       gauss, valid;
  logic [CW-1:0]              w_eff, col_sum;
  logic [ibd_pkg::DIM_W-1:0]  h_eff;
  logic [RW-1:0]              row_sum;
  logic                       col_ok, in_block, sc_end, sr_end, ic_last, ir_last;

  always_comb begin
    gauss = (scale == ibd_pkg::GAUSS_FACTOR);
    valid = gauss || (scale >= 5'd2 && !scale[0] && {2'b00, scale} <= MAXF);

    if (width == '0 || CW'(width) > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = CW'(width);
    end
    if (height == '0 || height > ibd_pkg::HEIGHT_LIMIT) begin
      h_eff = ibd_pkg::HEIGHT_LIMIT;
    end else begin
      h_eff = height;
    end

    col_sum    = CW'(ic_r) + CW'(scale);
    row_sum    = RW'(ir_r) + RW'(scale);
    col_ok     = (sc_r == '0) ? (col_sum <= w_eff) : 1'b1;
    row_ok_nxt = (sr_r == '0) ? (row_sum <= RW'(h_eff)) : row_ok_r;
    in_block   = valid && col_ok && row_ok_nxt;
    sc_end     = (EW'(sc_r) + EW'(1)) >= EW'(scale);
    sr_end     = (EW'(sr_r) + EW'(1)) >= EW'(scale);
    ic_last    = (CW'(ic_r) + CW'(1)) >= w_eff;
    ir_last    = (RW'(ir_r) + RW'(1)) >= RW'(h_eff);

    ctl.in_block  = in_block;
    ctl.sc0       = (sc_r == '0);
    ctl.first     = (sc_r == '0) && (sr_r == '0);
    ctl.wshift    = gauss ? (2'(sr_r == SW'(1)) + 2'(sc_r == SW'(1))) : 2'd0;
    ctl.blk_wr    = in_block && sc_end;
    ctl.last      = in_block && sc_end && sr_end;
    ctl.row_end   = col_sum >= w_eff;
    ctl.frame_end = (col_sum >= w_eff) && (row_sum >= RW'(h_eff));

    sc_nxt = sc_r;
    oc_nxt = oc_r;
    ic_nxt = ic_r;
    ir_nxt = ir_r;
    sr_nxt = sr_r;
    if (in_block) begin
      if (sc_end) begin
        sc_nxt = '0;
        oc_nxt = oc_r + AW'(1);
      end else begin
        sc_nxt = sc_r + SW'(1);
      end
    end
    if (ic_last) begin
      ic_nxt = '0;
      sc_nxt = '0;
      oc_nxt = '0;
      if (ir_last) begin
        ir_nxt = '0;
        sr_nxt = '0;
      end else begin
        ir_nxt = ir_r + ibd_pkg::ROW_W'(1);
        sr_nxt = (valid && !sr_end) ? sr_r + SW'(1) : '0;
      end
    end else begin
      ic_nxt = ic_r + ICW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      ic_r     <= '0;
      ir_r     <= '0;
      sc_r     <= '0;
      sr_r     <= '0;
      oc_r     <= '0;
      row_ok_r <= 1'b0;
    end else if (accept) begin
      ic_r     <= ic_nxt;
      ir_r     <= ir_nxt;
      sc_r     <= sc_nxt;
      sr_r     <= sr_nxt;
      oc_r     <= oc_nxt;
      row_ok_r <= row_ok_nxt;
    end
  end

  assign addr = oc_r;

endmodule

`default_nettype wire

// ===== rtl/ibd_lane.sv =====
`default_nettype none

module ibd_lane #(
  parameter int DEPTH = 2048,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                           clk,
  input  wire ibd_pkg::lane_cmd_t             cmd,
  input  wire logic [AW-1:0]                  rd_addr,
  input  wire logic [AW-1:0]                  wr_addr,
  input  wire logic [ibd_pkg::PIX_W-1:0]      pix,
  input  wire logic [ibd_pkg::RECIP_W-1:0]    recip,
  output logic      [ibd_pkg::PIX_W-1:0]      quo
);

  logic [ibd_pkg::PIX_W-1:0]  pix_r;
  logic [ibd_pkg::SUM_W-1:0]  acc_r, byp_r, sum_r, rdata, base, sum_nxt;
  logic                       hit_r;
  logic [ibd_pkg::PIX_W-1:0]  quo_r;
  logic [ibd_pkg::PROD_W-1:0] prod;

  // A column entry written at the same edge as it is read comes from the bypass.
  always_comb begin
    if (cmd.first) begin
      base = '0;
    end else if (cmd.sc0) begin
      base = hit_r ? byp_r : rdata;
    end else begin
      base = acc_r;
    end
    sum_nxt = base + (ibd_pkg::SUM_W'(pix_r) << cmd.wshift);
  end

  assign prod = ibd_pkg::PROD_W'(sum_r) * ibd_pkg::PROD_W'(recip);

  ibd_ram #(
    .DATA_W (ibd_pkg::SUM_W),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (sum_nxt),
    .re    (cmd.accept),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r <= pix;
      hit_r <= cmd.wr_en && (wr_addr == rd_addr);
      byp_r <= sum_nxt;
    end
    if (cmd.acc_en) begin
      acc_r <= sum_nxt;
    end
    if (cmd.load2) begin
      sum_r <= sum_nxt;
    end
    if (cmd.load3) begin
      quo_r <= prod[ibd_pkg::RECIP_SHIFT +: ibd_pkg::PIX_W];
    end
  end

  assign quo = quo_r;

endmodule

`default_nettype wire

// ===== rtl/image_block_downscaler.sv =====
// Channel  Direction  Transaction        Payload
// in_      slave      one input pixel    tdata: pix_a, pix_b, pix_c
// out_     master     one output pixel   tdata: out_a, out_b, out_c; tlast: row_end;
//                                        tuser: frame_end
// cfg_     APB slave  register access    scale_factor, frame_width, frame_height,
//                                        color_mode at byte addresses 0, 4, 8, 12
//
// One pixel is taken per cycle while in_tready is high; the pixel that closes a block
// passes the column-store read, the sum stage and the multiply before its result leaves.
// Reset is synchronous; the column store has no clearing pass and is ready at once.
// The input stalls only when the output register and the sum stage both hold results,
// out_tready is low and the pixel in the accumulate stage closes another block.
// Any register write restarts the frame position.
`default_nettype none

module image_block_downscaler #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // pix_a [7:0], pix_b [15:8], pix_c [23:16]

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // out_a [7:0], out_b [15:8], out_c [23:16]
  output logic             out_tlast,
  output logic             out_tuser,  // frame_end [0]

  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ibd_pkg::FACTOR_W-1:0] scale_r;
  logic [ibd_pkg::DIM_W-1:0]    width_r, height_r;
  logic                         color_r;
  logic [ibd_pkg::RECIP_W-1:0]  recip_r;

  logic                         cfg_wr;
  logic                         accept, retire, load2, load3;
  logic                         ready1, ready2, ready3;

  ibd_pkg::pix_ctl_t            ctl, s1_r;
  logic [AW-1:0]                ctl_addr, s1_addr_r;
  logic                         s1_v_r, s2_v_r, out_v_r;
  logic                         s2_re_r, s2_fe_r, out_re_r, out_fe_r;
  ibd_pkg::lane_cmd_t           cmd;
  logic [ibd_pkg::PIX_W-1:0]    pix_b, pix_c, quo_a, quo_b, quo_c;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= 5'd2;
      width_r  <= 13'd640;
      height_r <= 13'd480;
      color_r  <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        ibd_pkg::REG_SCALE:  scale_r  <= cfg_pwdata[ibd_pkg::FACTOR_W-1:0];
        ibd_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[ibd_pkg::DIM_W-1:0];
        ibd_pkg::REG_HEIGHT: height_r <= cfg_pwdata[ibd_pkg::DIM_W-1:0];
        ibd_pkg::REG_COLOR:  color_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      ibd_pkg::REG_SCALE:  cfg_prdata = 32'(scale_r);
      ibd_pkg::REG_WIDTH:  cfg_prdata = 32'(width_r);
      ibd_pkg::REG_HEIGHT: cfg_prdata = 32'(height_r);
      ibd_pkg::REG_COLOR:  cfg_prdata = 32'(color_r);
      default:             cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    recip_r <= ibd_pkg::recip_of(scale_r);
  end

  ibd_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .restart (cfg_wr),
    .scale   (scale_r),
    .width   (width_r),
    .height  (height_r),
    .ctl     (ctl),
    .addr    (ctl_addr)
  );

  assign ready3    = !out_v_r || out_tready;
  assign ready2    = !s2_v_r || ready3;
  assign ready1    = !(s1_v_r && s1_r.last) || ready2;
  assign in_tready = ready1;
  assign accept    = in_tvalid && in_tready;
  assign retire    = s1_v_r && ready1;
  assign load2     = retire && s1_r.last;
  assign load3     = s2_v_r && ready3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept || (s1_v_r && !retire);
      if (load2) begin
        s2_v_r <= 1'b1;
      end else if (load3) begin
        s2_v_r <= 1'b0;
      end
      if (load3) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r      <= ctl;
      s1_addr_r <= ctl_addr;
    end
    if (load2) begin
      s2_re_r <= s1_r.row_end;
      s2_fe_r <= s1_r.frame_end;
    end
    if (load3) begin
      out_re_r <= s2_re_r;
      out_fe_r <= s2_fe_r;
    end
  end

  always_comb begin
    cmd.accept = accept;
    cmd.acc_en = retire && s1_r.in_block;
    cmd.wr_en  = retire && s1_r.blk_wr;
    cmd.load2  = load2;
    cmd.load3  = load3;
    cmd.first  = s1_r.first;
    cmd.sc0    = s1_r.sc0;
    cmd.wshift = s1_r.wshift;
  end

  assign pix_b = color_r ? in_tdata[15:8]  : '0;
  assign pix_c = color_r ? in_tdata[23:16] : '0;

  ibd_lane #(.DEPTH(DEPTH)) u_lane_a (
    .clk     (clk),
    .cmd     (cmd),
    .rd_addr (ctl_addr),
    .wr_addr (s1_addr_r),
    .pix     (in_tdata[7:0]),
    .recip   (recip_r),
    .quo     (quo_a)
  );

  ibd_lane #(.DEPTH(DEPTH)) u_lane_b (
    .clk     (clk),
    .cmd     (cmd),
    .rd_addr (ctl_addr),
    .wr_addr (s1_addr_r),
    .pix     (pix_b),
    .recip   (recip_r),
    .quo     (quo_b)
  );

  ibd_lane #(.DEPTH(DEPTH)) u_lane_c (
    .clk     (clk),
    .cmd     (cmd),
    .rd_addr (ctl_addr),
    .wr_addr (s1_addr_r),
    .pix     (pix_c),
    .recip   (recip_r),
    .quo     (quo_c)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {quo_c, quo_b, quo_a};
  assign out_tlast  = out_re_r;
  assign out_tuser  = out_fe_r;

  a_no_s2_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load2 |-> (!s2_v_r || load3))
    else $error("sum stage overwritten while holding a result");

  a_s1_free_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (!s1_v_r || retire))
    else $error("pixel accepted while the accumulate stage is blocked");

  a_result_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_r.last) |-> (s1_r.in_block && s1_r.blk_wr))
    else $error("block result outside a complete block");

  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("frame end without row end");

endmodule

`default_nettype wire
